@@ rtl/trtt_pkg.sv @@
// ----------------------------------------------------------------------------
// trtt_pkg
// Shared types and constants of the TCP retransmission / time-wait timer table.
// ----------------------------------------------------------------------------
package trtt_pkg;

    // Input command codes
    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_ARM_RT   = 3'd1;
    localparam logic [2:0] CMD_ACK      = 3'd2;
    localparam logic [2:0] CMD_UNSET_RT = 3'd3;
    localparam logic [2:0] CMD_ARM_TW   = 3'd4;
    localparam logic [2:0] CMD_CLOSE    = 3'd5;

    // Internal operation codes after classification
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_ARM_RT = 3'd1;
    localparam logic [2:0] OP_DISARM = 3'd2;
    localparam logic [2:0] OP_ARM_TW = 3'd3;
    localparam logic [2:0] OP_CLOSE  = 3'd4;

    // Event kinds
    localparam logic [1:0] KIND_RETRANS = 2'd0;
    localparam logic [1:0] KIND_RESET   = 2'd1;
    localparam logic [1:0] KIND_CLOSED  = 2'd2;
    localparam logic [1:0] KIND_WAKE    = 2'd3;

    // Register indexes
    localparam logic [1:0] REG_RTO  = 2'd0;
    localparam logic [1:0] REG_MAXR = 2'd1;
    localparam logic [1:0] REG_TW   = 2'd2;

    // Register reset values
    localparam logic [15:0] RTO_RST  = 16'd2;
    localparam logic [3:0]  MAXR_RST = 4'd3;
    localparam logic [15:0] TW_RST   = 16'd2;

    // Queue sizes
    localparam int CQ_DEPTH  = 2;
    localparam int EVQ_DEPTH = 4;

    typedef struct packed {
        logic [15:0] rto;
        logic [3:0]  maxr;
        logic [15:0] tw;
    } t_cfg;

    // One slot of the timer table
    typedef struct packed {
        logic        rarm;
        logic [31:0] rrem;
        logic [3:0]  ret;
        logic        twarm;
        logic [15:0] twrem;
        logic        closed;
    } t_entry;

    typedef struct packed {
        logic [3:0] conn;
        logic [1:0] kind;
        logic [3:0] retry;
        logic       last;
    } t_evt;

    // Up to two events written into the event queue per cycle, e0 first
    typedef struct packed {
        logic v0;
        t_evt e0;
        logic v1;
        t_evt e1;
    } t_push;

endpackage

@@ rtl/trtt_ram.sv @@
// ----------------------------------------------------------------------------
// trtt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module trtt_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                        i_wdata,
    input  logic                                i_re,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                        o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/trtt_front.sv @@
// ----------------------------------------------------------------------------
// trtt_front
// Accepts commands, drops unknown codes, out-of-range slots and acks with a non-empty send buffer, queues the rest.
// ----------------------------------------------------------------------------
module trtt_front
    import trtt_pkg::*;
#(
    parameter int NUM_CONN = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_in_valid,
    output logic                                        o_in_stall,
    input  logic [2:0]                                  i_cmd,
    input  logic [3:0]                                  i_conn,
    input  logic                                        i_send_buffer_empty,
    output logic                                        o_cmd_valid,
    output logic [2:0]                                  o_cmd_op,
    output logic [((NUM_CONN > 1) ? $clog2(NUM_CONN) : 1)-1:0] o_cmd_slot,
    input  logic                                        i_cmd_take
);

    localparam int SLOT_W = (NUM_CONN > 1) ? $clog2(NUM_CONN) : 1;
    localparam int CQ_AW  = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
    localparam int CQ_CW  = $clog2(CQ_DEPTH + 1);

    logic [2:0]        r_op   [CQ_DEPTH];
    logic [SLOT_W-1:0] r_slot [CQ_DEPTH];
    logic [CQ_AW-1:0]  r_wp, r_rp;
    logic [CQ_CW-1:0]  r_cnt;

    logic       w_in_range;
    logic       w_keep;
    logic [2:0] w_op;
    logic       w_push;
    logic       w_pop;

    // Classify: ticks always go through; slot commands need an in-range slot, and acks an empty send buffer
    always_comb begin
        w_in_range = ({28'd0, i_conn} < 32'(NUM_CONN));
        w_keep     = 1'b0;
        w_op       = OP_TICK;
        case (i_cmd)
            CMD_TICK: begin
                w_keep = 1'b1;
                w_op   = OP_TICK;
            end
            CMD_ARM_RT: begin
                w_keep = w_in_range;
                w_op   = OP_ARM_RT;
            end
            CMD_ACK: begin
                w_keep = w_in_range & i_send_buffer_empty;
                w_op   = OP_DISARM;
            end
            CMD_UNSET_RT: begin
                w_keep = w_in_range;
                w_op   = OP_DISARM;
            end
            CMD_ARM_TW: begin
                w_keep = w_in_range;
                w_op   = OP_ARM_TW;
            end
            CMD_CLOSE: begin
                w_keep = w_in_range;
                w_op   = OP_CLOSE;
            end
            default: begin
                w_keep = 1'b0;
                w_op   = OP_TICK;
            end
        endcase
    end

    assign o_in_stall = (r_cnt == CQ_CW'(CQ_DEPTH));
    assign w_push     = i_in_valid & ~o_in_stall & w_keep;
    assign w_pop      = i_cmd_take & (r_cnt != '0);

    // Command queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CQ_CW'(w_push) - CQ_CW'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_op[r_wp]   <= w_op;
            r_slot[r_wp] <= SLOT_W'(i_conn);
        end
    end

    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd_op    = r_op[r_rp];
    assign o_cmd_slot  = r_slot[r_rp];

endmodule

@@ rtl/trtt_evq.sv @@
// ----------------------------------------------------------------------------
// trtt_evq
// Event queue toward the output channel; takes up to two events per cycle.
// ----------------------------------------------------------------------------
module trtt_evq
    import trtt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_push      i_push,
    output logic       o_room,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_evt       o_evt
);

    localparam int AW = $clog2(EVQ_DEPTH);
    localparam int CW = $clog2(EVQ_DEPTH + 1);

    t_evt          r_mem [EVQ_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    logic [AW-1:0] w_wp1;
    logic          w_pop;
    logic [CW-1:0] w_npush;

    assign w_wp1   = r_wp + 1'b1;
    assign w_pop   = (r_cnt != '0) & ~i_out_stall;
    assign w_npush = CW'(i_push.v0) + CW'(i_push.v0 & i_push.v1);

    // Room for two more events, ignoring a pop in the same cycle
    assign o_room = (r_cnt <= CW'(EVQ_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + AW'(w_npush);
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + w_npush - CW'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wp] <= i_push.e0;
            if (i_push.v1) begin
                r_mem[w_wp1] <= i_push.e1;
            end
        end
    end

    assign o_out_valid = (r_cnt != '0);
    assign o_evt       = r_mem[r_rp];

endmodule

@@ rtl/trtt_back.sv @@
// ----------------------------------------------------------------------------
// trtt_back
// Executes queued commands on the timer table: read-modify-write per slot,
// a tick sweeps all slots, one slot per cycle while the event queue has room.
// ----------------------------------------------------------------------------
module trtt_back
    import trtt_pkg::*;
#(
    parameter int NUM_CONN = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  t_cfg                                        i_cfg,
    input  logic                                        i_cmd_valid,
    input  logic [2:0]                                  i_cmd_op,
    input  logic [((NUM_CONN > 1) ? $clog2(NUM_CONN) : 1)-1:0] i_cmd_slot,
    output logic                                        o_cmd_take,
    input  logic                                        i_room,
    output t_push                                       o_push
);

    localparam int SLOT_W = (NUM_CONN > 1) ? $clog2(NUM_CONN) : 1;
    localparam int ENT_W  = $bits(t_entry);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [SLOT_W-1:0]   r_idx, n_idx;
    logic [2:0]          r_op, n_op;
    logic                r_pend_v, n_pend_v;
    t_evt                r_pend, n_pend;
    logic [NUM_CONN-1:0] r_vld;
    logic                r_rd_vld;

    logic              w_re, w_we;
    logic [SLOT_W-1:0] w_raddr;
    logic [ENT_W-1:0]  w_rdata;
    t_entry            w_ent;
    t_entry            w_wr;

    // Tick datapath
    t_entry      w_tk;
    logic        w_a_v, w_b_v;
    t_evt        w_a, w_b;
    logic [31:0] w_rrem_dec;
    logic [15:0] w_twrem_dec;
    logic [3:0]  w_ret_inc;
    logic [31:0] w_backoff;

    // Single-slot datapath
    t_entry      w_sg;
    logic        w_sg_v;
    t_evt        w_sg_evt;

    trtt_ram #(
        .W (ENT_W),
        .D (NUM_CONN)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_idx),
        .i_wdata (w_wr),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Slots never written read as all zero
    assign w_ent = r_rd_vld ? t_entry'(w_rdata) : '0;

    // Tick on one slot: retransmission timer first, then time-wait
    always_comb begin
        w_tk        = w_ent;
        w_a_v       = 1'b0;
        w_b_v       = 1'b0;
        w_rrem_dec  = (w_ent.rrem == 32'd0) ? 32'd0 : w_ent.rrem - 32'd1;
        w_twrem_dec = (w_ent.twrem == 16'd0) ? 16'd0 : w_ent.twrem - 16'd1;
        w_ret_inc   = w_ent.ret + 4'd1;
        // base fits 16 bits and shift is below 16, so this never overflows
        w_backoff   = {16'd0, i_cfg.rto} << w_ret_inc;
        w_a         = '{conn: 4'(r_idx), kind: KIND_RETRANS, retry: w_ent.ret, last: 1'b0};
        w_b         = '{conn: 4'(r_idx), kind: KIND_CLOSED, retry: w_ent.ret, last: 1'b0};
        if (w_ent.rarm) begin
            w_tk.rrem = w_rrem_dec;
            if (w_rrem_dec == 32'd0 && !w_ent.closed) begin
                w_a_v = 1'b1;
                if (w_ent.ret >= i_cfg.maxr) begin
                    w_tk.rarm   = 1'b0;
                    w_tk.closed = 1'b1;
                    w_a.kind    = KIND_RESET;
                end else begin
                    w_tk.ret  = w_ret_inc;
                    w_tk.rrem = w_backoff;
                    w_a.retry = w_ret_inc;
                end
            end
        end
        w_b.retry = w_tk.ret;
        if (w_ent.twarm) begin
            w_tk.twrem = w_twrem_dec;
            if (w_twrem_dec == 16'd0) begin
                w_b_v       = 1'b1;
                w_tk.twarm  = 1'b0;
                w_tk.closed = 1'b1;
            end
        end
    end

    // Single-slot commands
    always_comb begin
        w_sg     = w_ent;
        w_sg_v   = 1'b0;
        w_sg_evt = '{conn: 4'(r_idx), kind: KIND_WAKE, retry: w_ent.ret, last: 1'b1};
        case (r_op)
            OP_ARM_RT: begin
                if (!w_ent.rarm) begin
                    w_sg.rarm = 1'b1;
                    w_sg.ret  = 4'd0;
                end
                w_sg.rrem = {16'd0, i_cfg.rto};
            end
            OP_DISARM: begin
                if (w_ent.rarm) begin
                    w_sg.rarm = 1'b0;
                    w_sg_v    = 1'b1;
                end
            end
            OP_ARM_TW: begin
                w_sg.twarm = 1'b1;
                w_sg.twrem = i_cfg.tw;
            end
            OP_CLOSE: begin
                w_sg.closed = 1'b1;
            end
            default: begin
                w_sg = w_ent;
            end
        endcase
    end

    // Sequencer; the last event of a tick is held back until its end is known
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_op       = r_op;
        n_pend_v   = r_pend_v;
        n_pend     = r_pend;
        w_re       = 1'b0;
        w_raddr    = r_idx + 1'b1;
        w_we       = 1'b0;
        w_wr       = w_sg;
        o_push     = '0;
        o_cmd_take = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_take = 1'b1;
                    w_re       = 1'b1;
                    w_raddr    = (i_cmd_op == OP_TICK) ? '0 : i_cmd_slot;
                    n_idx      = w_raddr;
                    n_op       = i_cmd_op;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_room) begin
                    w_we = 1'b1;
                    if (r_op == OP_TICK) begin
                        w_wr = w_tk;
                        if (w_a_v && w_b_v) begin
                            o_push.v0 = 1'b1;
                            o_push.e0 = r_pend_v ? r_pend : w_a;
                            o_push.v1 = r_pend_v;
                            o_push.e1 = w_a;
                            n_pend_v  = 1'b1;
                            n_pend    = w_b;
                        end else if (w_a_v || w_b_v) begin
                            o_push.v0 = r_pend_v;
                            o_push.e0 = r_pend;
                            n_pend_v  = 1'b1;
                            n_pend    = w_a_v ? w_a : w_b;
                        end
                        if (r_idx == SLOT_W'(NUM_CONN - 1)) begin
                            n_state = S_FLUSH;
                        end else begin
                            w_re  = 1'b1;
                            n_idx = w_raddr;
                        end
                    end else begin
                        w_wr      = w_sg;
                        o_push.v0 = w_sg_v;
                        o_push.e0 = w_sg_evt;
                        n_state   = S_IDLE;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = S_IDLE;
                end else if (i_room) begin
                    o_push.v0      = 1'b1;
                    o_push.e0      = r_pend;
                    o_push.e0.last = 1'b1;
                    n_pend_v       = 1'b0;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pend_v <= 1'b0;
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pend_v <= n_pend_v;
            if (w_we) begin
                r_vld[r_idx] <= 1'b1;
            end
            if (w_re) begin
                r_rd_vld <= r_vld[w_raddr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_op   <= n_op;
        r_pend <= n_pend;
    end

endmodule

@@ rtl/tcp_retrans_timewait_timer_table_top.sv @@
// ----------------------------------------------------------------------------
// tcp_retrans_timewait_timer_table_top
// Per-connection retransmission (with exponential backoff) and time-wait timers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries commands: tick, arm
//   retransmission, ack progress, unset retransmission, arm time-wait, close.
//   Output channel (o_out_valid / i_out_stall) carries events; o_last marks
//   the final event a command caused. Commands that cause no event give none.
//   A two-entry command queue decouples intake from execution, and a
//   four-entry event queue decouples execution from the output receiver.
//   A slot command is executed as a table read, then a write, and its event
//   is pushed into the event queue with the write. A tick sweeps the table
//   one slot per cycle while the event queue has room. Unknown, out-of-range
//   and non-empty-buffer ack commands are dropped on entry.
//   When the receiver stalls, the event queue fills, the sweep pauses, and
//   then the command queue fills and o_in_stall rises.
//   Reset (synchronous, active low) clears all timers, flags and queues and
//   loads the registers with rto 2, max retries 3, time-wait 2.
//   Registers (APB, pready always high): 0x0 rto, 0x4 max retries,
//   0x8 time-wait; write only while the block is idle.
// ----------------------------------------------------------------------------
module tcp_retrans_timewait_timer_table_top
    import trtt_pkg::*;
#(
    parameter int NUM_CONN = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_cmd,
    input  logic [3:0]  i_conn,
    input  logic        i_send_buffer_empty,
    // event channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_event_conn,
    output logic [1:0]  o_event_kind,
    output logic [3:0]  o_retry_count,
    output logic        o_last,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SLOT_W = (NUM_CONN > 1) ? $clog2(NUM_CONN) : 1;

    t_cfg              r_cfg;
    logic              w_wr;
    logic              w_cmd_valid;
    logic [2:0]        w_cmd_op;
    logic [SLOT_W-1:0] w_cmd_slot;
    logic              w_cmd_take;
    logic              w_room;
    t_push             w_push;
    t_evt              w_evt;

    // Register writes
    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rto  <= RTO_RST;
            r_cfg.maxr <= MAXR_RST;
            r_cfg.tw   <= TW_RST;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_RTO:  r_cfg.rto  <= pwdata[15:0];
                REG_MAXR: r_cfg.maxr <= pwdata[3:0];
                REG_TW:   r_cfg.tw   <= pwdata[15:0];
                default:  r_cfg      <= r_cfg;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (paddr[3:2])
            REG_RTO:  prdata = {16'd0, r_cfg.rto};
            REG_MAXR: prdata = {28'd0, r_cfg.maxr};
            REG_TW:   prdata = {16'd0, r_cfg.tw};
            default:  prdata = 32'd0;
        endcase
    end

    trtt_front #(
        .NUM_CONN (NUM_CONN)
    ) u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_cmd               (i_cmd),
        .i_conn              (i_conn),
        .i_send_buffer_empty (i_send_buffer_empty),
        .o_cmd_valid         (w_cmd_valid),
        .o_cmd_op            (w_cmd_op),
        .o_cmd_slot          (w_cmd_slot),
        .i_cmd_take          (w_cmd_take)
    );

    trtt_back #(
        .NUM_CONN (NUM_CONN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd_op    (w_cmd_op),
        .i_cmd_slot  (w_cmd_slot),
        .o_cmd_take  (w_cmd_take),
        .i_room      (w_room),
        .o_push      (w_push)
    );

    trtt_evq u_evq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .o_room      (w_room),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_evt       (w_evt)
    );

    assign o_event_conn  = w_evt.conn;
    assign o_event_kind  = w_evt.kind;
    assign o_retry_count = w_evt.retry;
    assign o_last        = w_evt.last;

endmodule

@@ dv/tcp_retrans_timewait_timer_table_top_test.sv @@
// ----------------------------------------------------------------------------
// tcp_retrans_timewait_timer_table_top_test
// Self-checking bench for the TCP retransmission / time-wait timer table.
// Commands go in over the valid/stall command channel. A behavioral copy of
// the timer table predicts the events each accepted command causes, and each
// event transfer is checked field by field against the oldest prediction.
// Directed tests come first, then random traffic under several register
// settings, and last a long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tcp_retrans_timewait_timer_table_top_test;
    import trtt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CONN = 16;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 64;
    // Command codes the block has no meaning for
    localparam logic [2:0] CMD_BAD_LO = 3'd6;
    localparam logic [2:0] CMD_BAD_HI = 3'd7;

    // DUT inputs, all known from time zero
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [2:0]  i_cmd = CMD_TICK;
    logic [3:0]  i_conn = '0;
    logic        i_send_buffer_empty = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [3:0]  o_event_conn;
    logic [1:0]  o_event_kind;
    logic [3:0]  o_retry_count;
    logic        o_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Shadow of the register file
    logic [15:0] rto_ticks = RTO_RST;
    logic [3:0]  retry_limit = MAXR_RST;
    logic [15:0] tw_ticks = TW_RST;

    // Shadow of the timer table
    logic        rt_armed [NUM_CONN];
    logic [31:0] rt_left  [NUM_CONN];
    logic [3:0]  rt_tries [NUM_CONN];
    logic        tw_armed [NUM_CONN];
    logic [15:0] tw_left  [NUM_CONN];
    logic        slot_closed [NUM_CONN];

    t_evt pending_events[$];
    int   err_cnt = 0;
    int   cycle_cnt = 0;

    // Pacing controls, written by the test process only
    logic tx_quiet = 1'b0;
    logic rx_quiet = 1'b0;
    logic hold_req = 1'b0;
    int   hold_len = 0;

    // Receiver pacing state
    logic hold_ack = 1'b0;
    int   hold_left = 0;
    int   rx_wait = 0;

    tcp_retrans_timewait_timer_table_top #(.NUM_CONN(NUM_CONN)) dut (.*);

    // Clock: 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        for (int s = 0; s < NUM_CONN; s++) begin
            rt_armed[s] = 1'b0;
            rt_left[s] = '0;
            rt_tries[s] = '0;
            tw_armed[s] = 1'b0;
            tw_left[s] = '0;
            slot_closed[s] = 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Timer table prediction
    // ------------------------------------------------------------------------
    function automatic t_evt make_evt(input int s, input logic [1:0] kind,
                                      input logic [3:0] tries);
        t_evt e;
        e.conn = 4'(s);
        e.kind = kind;
        e.retry = tries;
        e.last = 1'b0;
        return e;
    endfunction

    // Initial timeout shifted left by the retry count, saturated to 32 bits
    function automatic logic [31:0] backoff_ticks(input logic [15:0] base,
                                                  input logic [3:0] tries);
        logic [47:0] wide;
        wide = {32'd0, base} << tries;
        return (wide[47:32] != 0) ? 32'hFFFF_FFFF : wide[31:0];
    endfunction

    task automatic predict_cmd(input logic [2:0] cmd, input logic [3:0] c,
                               input logic empty);
        t_evt evs[$];
        if (cmd == CMD_TICK) begin
            // Sweep slots in order: retransmission first, then time-wait
            for (int s = 0; s < NUM_CONN; s++) begin
                if (rt_armed[s]) begin
                    if (rt_left[s] != 0) rt_left[s] = rt_left[s] - 1;
                    if (rt_left[s] == 0 && !slot_closed[s]) begin
                        if (rt_tries[s] >= retry_limit) begin
                            rt_armed[s] = 1'b0;
                            slot_closed[s] = 1'b1;
                            evs.push_back(make_evt(s, KIND_RESET, rt_tries[s]));
                        end else begin
                            rt_tries[s] = rt_tries[s] + 1;
                            rt_left[s] = backoff_ticks(rto_ticks, rt_tries[s]);
                            evs.push_back(make_evt(s, KIND_RETRANS, rt_tries[s]));
                        end
                    end
                end
                if (tw_armed[s]) begin
                    if (tw_left[s] != 0) tw_left[s] = tw_left[s] - 1;
                    if (tw_left[s] == 0) begin
                        tw_armed[s] = 1'b0;
                        slot_closed[s] = 1'b1;
                        evs.push_back(make_evt(s, KIND_CLOSED, rt_tries[s]));
                    end
                end
            end
        end else if (int'(c) < NUM_CONN) begin
            case (cmd)
                CMD_ARM_RT: begin
                    if (!rt_armed[c]) begin
                        rt_armed[c] = 1'b1;
                        rt_tries[c] = '0;
                    end
                    rt_left[c] = 32'(rto_ticks);
                end
                CMD_ACK, CMD_UNSET_RT: begin
                    // ack progress only disarms once the send buffer is empty
                    if (rt_armed[c] && (cmd == CMD_UNSET_RT || empty)) begin
                        rt_armed[c] = 1'b0;
                        evs.push_back(make_evt(int'(c), KIND_WAKE, rt_tries[c]));
                    end
                end
                CMD_ARM_TW: begin
                    tw_armed[c] = 1'b1;
                    tw_left[c] = tw_ticks;
                end
                CMD_CLOSE: slot_closed[c] = 1'b1;
                default: ;
            endcase
        end
        if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
        foreach (evs[i]) pending_events.push_back(evs[i]);
    endtask

    // ------------------------------------------------------------------------
    // Command intake and event checking, both on the same clock edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        t_evt got;
        t_evt want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                predict_cmd(i_cmd, i_conn, i_send_buffer_empty);
            if (o_out_valid && !i_out_stall) begin
                got.conn = o_event_conn;
                got.kind = o_event_kind;
                got.retry = o_retry_count;
                got.last = o_last;
                if (pending_events.size() == 0) begin
                    $display("%0t: unexpected event conn %0d kind %0d retry %0d last %0d",
                             $time, got.conn, got.kind, got.retry, got.last);
                    err_cnt++;
                end else begin
                    want = pending_events.pop_front();
                    if (got !== want) begin
                        $display("%0t: event mismatch, expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                                 $time, want.conn, want.kind, want.retry, want.last,
                                 got.conn, got.kind, got.retry, got.last);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Event receiver: random stall before each transfer, plus long hold-offs
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : rx_pace
        int gap;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_wait <= 0;
            hold_left <= 0;
            hold_ack <= hold_req;
        end else if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_left <= hold_len;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= (hold_left > 1);
        end else if (o_out_valid && !i_out_stall) begin
            gap = rx_quiet ? 0 : $urandom_range(0, 7);
            rx_wait <= gap;
            i_out_stall <= (gap != 0);
        end else if (rx_wait != 0) begin
            rx_wait <= rx_wait - 1;
            i_out_stall <= (rx_wait > 1);
        end
    end

    // ------------------------------------------------------------------------
    // Shared driver tasks (called right after a rising edge)
    // ------------------------------------------------------------------------
    task automatic send_cmd(input logic [2:0] cmd, input logic [3:0] c,
                            input logic empty);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_conn <= c;
        i_send_buffer_empty <= empty;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_random_cmd();
        int pick;
        logic [2:0] cmd;
        pick = $urandom_range(0, 99);
        if (pick < 35) cmd = CMD_TICK;
        else if (pick < 62) cmd = CMD_ARM_RT;
        else if (pick < 76) cmd = CMD_ACK;
        else if (pick < 84) cmd = CMD_UNSET_RT;
        else if (pick < 91) cmd = CMD_ARM_TW;
        else if (pick < 95) cmd = CMD_CLOSE;
        else cmd = 3'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
        send_cmd(cmd, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    endtask

    // Let every predicted event out, then give the block time to finish
    // commands that cause none
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_RTO:  rto_ticks = val[15:0];
            REG_MAXR: retry_limit = val[3:0];
            REG_TW:   tw_ticks = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_timers(input logic [15:0] rto, input logic [3:0] maxr,
                              input logic [15:0] tw);
        write_reg(REG_RTO, 32'(rto));
        write_reg(REG_MAXR, 32'(maxr));
        write_reg(REG_TW, 32'(tw));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset settings: expiry with backoff on the edge slots, time-wait close,
    // re-arm of an armed timer keeping its retry count
    task automatic test_timer_basics();
        send_cmd(CMD_ARM_RT, 4'd0, 1'b0);
        send_cmd(CMD_ARM_RT, 4'd15, 1'b1);
        send_cmd(CMD_ARM_TW, 4'd15, 1'b0);
        send_cmd(CMD_TICK, 4'd0, 1'b0);
        send_cmd(CMD_TICK, 4'd15, 1'b1);
        send_cmd(CMD_ARM_RT, 4'd0, 1'b0);
    endtask

    // Ack with and without empty buffer, unset armed and unarmed, unknown
    // codes, expiry on a closed slot, time-wait reload
    task automatic test_command_corners();
        send_cmd(CMD_ACK, 4'd0, 1'b0);
        send_cmd(CMD_ACK, 4'd15, 1'b1);
        send_cmd(CMD_UNSET_RT, 4'd15, 1'b0);
        send_cmd(CMD_UNSET_RT, 4'd0, 1'b1);
        send_cmd(CMD_BAD_LO, 4'd10, 1'b1);
        send_cmd(CMD_BAD_HI, 4'd5, 1'b0);
        send_cmd(CMD_CLOSE, 4'd3, 1'b0);
        send_cmd(CMD_ARM_RT, 4'd3, 1'b0);
        send_cmd(CMD_ARM_TW, 4'd7, 1'b0);
        send_cmd(CMD_ARM_TW, 4'd7, 1'b1);
        repeat (3) send_cmd(CMD_TICK, 4'($urandom_range(0, 15)), 1'b0);
        wait_idle();
    endtask

    // Zero retry limit gives up on the first expiry; then the widest settings
    task automatic test_giveup_and_extremes();
        set_timers(16'd1, 4'd0, 16'd1);
        send_cmd(CMD_ARM_RT, 4'd5, 1'b0);
        send_cmd(CMD_TICK, 4'd0, 1'b0);
        wait_idle();
        set_timers(16'hFFFF, 4'd15, 16'hFFFF);
        send_cmd(CMD_ARM_RT, 4'd9, 1'b0);
        send_cmd(CMD_ARM_TW, 4'd9, 1'b1);
        wait_idle();
    endtask

    task automatic test_random_traffic(input int n, input logic [15:0] rto,
                                       input logic [3:0] maxr, input logic [15:0] tw,
                                       input logic quiet);
        set_timers(rto, maxr, tw);
        tx_quiet = quiet;
        rx_quiet = quiet;
        repeat (n) send_random_cmd();
        wait_idle();
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    // Receiver holds off while every slot expires at once; the event queue
    // fills, the sweep pauses and the command channel stalls
    task automatic test_backpressure();
        set_timers(16'd1, 4'd1, 16'd1);
        tx_quiet = 1'b1;
        hold_len = 600;
        hold_req = ~hold_req;
        for (int s = 0; s < NUM_CONN; s++) send_cmd(CMD_ARM_RT, 4'(s), 1'b0);
        for (int s = 0; s < NUM_CONN; s++) send_cmd(CMD_ARM_TW, 4'(s), 1'b1);
        repeat (5) send_cmd(CMD_TICK, 4'd0, 1'b0);
        wait_idle();
        tx_quiet = 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_timer_basics();
        test_command_corners();
        test_giveup_and_extremes();
        test_random_traffic(16, 16'd1, 4'd2, 16'd3, 1'b0);
        test_random_traffic(16, 16'd2, 4'd15, 16'd1, 1'b1);
        test_random_traffic(16, 16'd3, 4'd1, 16'd5, 1'b0);
        test_backpressure();

        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ tcp_retrans_timewait_timer_table_top.f @@
rtl/trtt_pkg.sv
rtl/trtt_ram.sv
rtl/trtt_front.sv
rtl/trtt_evq.sv
rtl/trtt_back.sv
rtl/tcp_retrans_timewait_timer_table_top.sv
dv/tcp_retrans_timewait_timer_table_top_test.sv
